// ===== hw/rtl/vtp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vtp_pkg
// Shared constants and types for the hydraulic valve torque PID.
// ----------------------------------------------------------------------------
package vtp_pkg;

   localparam int NUM_JOINTS = 16;
   localparam int JOINT_W    = 4;
   localparam int ADDR_W     = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;
   localparam int TORQUE_W   = 16;
   localparam int ERR_W      = TORQUE_W + 1;
   localparam int INTEG_W    = 32;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_P_GAIN         = 3'd0,
      CSR_D_GAIN_SCALED  = 3'd1,
      CSR_I_GAIN         = 3'd2,
      CSR_INTEGRAL_LIMIT = 3'd3,
      CSR_FORGET_COEF    = 3'd4,
      CSR_VEL_GAIN       = 3'd5,
      CSR_VALVE_LIMIT    = 3'd6,
      CSR_VALVE_BIAS     = 3'd7
   } csr_reg_type;

   localparam logic [16:0] FORGET_RESET = 17'd65;

   // per-joint word; the integral is clamped to a 31-bit limit so 32 bits hold it
   typedef struct packed {
      logic                      sat;
      logic signed [ERR_W-1:0]   last_err;
      logic signed [INTEG_W-1:0] integ;
   } vtp_state_type;

endpackage
`default_nettype wire

// ===== hw/rtl/valve_torque_pid.sv =====
`default_nettype none
// Pipeline: a request passes through stages b, c, d and e into the output register.
// Throughput: one item per cycle while the response side does not stall; a request
//   for the same joint as the item just accepted waits until that item leaves stage b
//   (joint state is written back in the integral stage and the state memory read is registered).
// Reset: config registers take their reset values, joint state reads as zero
//   through per-entry valid bits, no clearing pass.
// ----------------------------------------------------------------------------
// valve_torque_pid
// Multi-joint torque PID with leaky integrator, velocity feedforward and bias.
// ----------------------------------------------------------------------------
module valve_torque_pid (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [vtp_pkg::JOINT_W-1:0]           req_joint,
   input  logic signed [vtp_pkg::TORQUE_W-1:0]   req_desired_torque,
   input  logic signed [vtp_pkg::TORQUE_W-1:0]   req_actual_torque,
   input  logic signed [15:0]                    req_piston_velocity,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [vtp_pkg::JOINT_W-1:0]           rsp_joint_out,
   output logic signed [15:0]                    rsp_valve_command,
   output logic                                  rsp_integral_saturated,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [vtp_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [vtp_pkg::CSR_DATA_W-1:0]        csr_wdata
);
   import vtp_pkg::*;

   localparam logic [JOINT_W:0] JOINT_LIMIT = (JOINT_W + 1)'(NUM_JOINTS);

   // configuration
   logic signed [31:0] p_gain_ff, d_gain_ff, i_gain_ff, vel_gain_ff;
   logic [30:0]        integ_lim_ff;
   logic [16:0]        forget_ff;
   logic [14:0]        valve_lim_ff;
   logic signed [15:0] valve_bias_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         p_gain_ff     <= '0;
         d_gain_ff     <= '0;
         i_gain_ff     <= '0;
         integ_lim_ff  <= '0;
         forget_ff     <= FORGET_RESET;
         vel_gain_ff   <= '0;
         valve_lim_ff  <= '0;
         valve_bias_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_reg_type'(csr_index))
            CSR_P_GAIN:         p_gain_ff     <= $signed(csr_wdata[31:0]);
            CSR_D_GAIN_SCALED:  d_gain_ff     <= $signed(csr_wdata[31:0]);
            CSR_I_GAIN:         i_gain_ff     <= $signed(csr_wdata[31:0]);
            CSR_INTEGRAL_LIMIT: integ_lim_ff  <= csr_wdata[30:0];
            CSR_FORGET_COEF:    forget_ff     <= csr_wdata[16:0];
            CSR_VEL_GAIN:       vel_gain_ff   <= $signed(csr_wdata[31:0]);
            CSR_VALVE_LIMIT:    valve_lim_ff  <= csr_wdata[14:0];
            CSR_VALVE_BIAS:     valve_bias_ff <= $signed(csr_wdata[15:0]);
            default: ;
         endcase
      end
   end

   // pipeline control
   logic en, hazard, accept;
   logic rsp_valid_ff;

   // stage b: memory data returns
   logic                       b_vld_ff, b_inr_ff;
   logic [JOINT_W-1:0]         b_joint_ff;
   logic signed [ERR_W-1:0]    b_err_ff;
   logic signed [15:0]         b_vel_ff;
   vtp_state_type              rd_q_ff;
   logic                       rd_vld_ff;

   // stage c: integral update and write back
   logic                       c_vld_ff, c_inr_ff;
   logic [JOINT_W-1:0]         c_joint_ff;
   logic signed [ERR_W-1:0]    c_err_ff;
   logic signed [INTEG_W-1:0]  c_integ_ff;
   logic signed [49:0]         c_leak_ff;
   logic signed [48:0]         c_ig_ff, c_pp_ff;
   logic signed [47:0]         c_vp_ff;
   logic signed [ERR_W:0]      c_derr_ff;

   // stage d: command sum
   logic                       d_vld_ff, d_inr_ff, d_sat_ff;
   logic [JOINT_W-1:0]         d_joint_ff;
   logic signed [ERR_W-1:0]    d_err_ff;
   logic signed [INTEG_W-1:0]  d_integ_ff;
   logic signed [49:0]         d_dp_ff;
   logic signed [57:0]         d_pv_ff;

   // stage e: clamp and scale
   logic                       e_vld_ff, e_inr_ff, e_sat_ff;
   logic [JOINT_W-1:0]         e_joint_ff;
   logic signed [61:0]         e_cmd_ff;

   // output register
   logic [JOINT_W-1:0]         rsp_joint_ff;
   logic signed [15:0]         rsp_cmd_ff;
   logic                       rsp_sat_ff;

   assign en        = !rsp_valid_ff || !rsp_stall;
   assign hazard    = b_vld_ff && (b_joint_ff == req_joint);
   assign req_stall = !en || hazard;
   assign accept    = req_valid && !req_stall;

   // stage a
   logic signed [ERR_W-1:0] err_in;
   logic                    inr_in;
   logic [ADDR_W-1:0]       rd_addr;

   assign err_in  = ERR_W'(req_desired_torque) - ERR_W'(req_actual_torque);
   assign inr_in  = ({1'b0, req_joint} < JOINT_LIMIT);
   assign rd_addr = req_joint[ADDR_W-1:0];

   // stage b
   logic                       fwd;
   logic signed [INTEG_W-1:0]  b_integ;
   logic signed [ERR_W-1:0]    b_lerr;
   logic signed [49:0]         leak_in;
   logic signed [48:0]         ig_in, pp_in;
   logic signed [47:0]         vp_in;
   logic signed [ERR_W:0]      derr_in;

   // the item two stages ahead wrote this joint as it was read; take its result
   assign fwd = d_vld_ff && d_inr_ff && (d_joint_ff == b_joint_ff);

   always_comb begin
      if (fwd) begin
         b_integ = d_integ_ff;
         b_lerr  = d_err_ff;
      end else if (rd_vld_ff) begin
         b_integ = rd_q_ff.integ;
         b_lerr  = rd_q_ff.last_err;
      end else begin
         b_integ = '0;
         b_lerr  = '0;
      end
   end

   assign leak_in = b_integ * $signed({1'b0, forget_ff});
   assign ig_in   = i_gain_ff * b_err_ff;
   assign pp_in   = p_gain_ff * b_err_ff;
   assign vp_in   = vel_gain_ff * b_vel_ff;
   assign derr_in = (ERR_W + 1)'(b_err_ff) - (ERR_W + 1)'(b_lerr);

   // stage c
   logic signed [33:0]        leak_sh;
   logic                      leak_rnd;
   logic signed [49:0]        isum, ilim;
   logic signed [INTEG_W-1:0] integ_new_in;
   logic                      sat_in;
   logic signed [49:0]        dp_in;
   logic signed [57:0]        pv_in;
   logic                      wr_en;
   logic [ADDR_W-1:0]         wr_addr;

   assign leak_sh  = c_leak_ff[49:16];
   // leak truncates toward zero
   assign leak_rnd = c_leak_ff[49] && (|c_leak_ff[15:0]);
   assign isum     = 50'(c_integ_ff) - 50'(leak_sh) - $signed({49'd0, leak_rnd})
                     + 50'(c_ig_ff);
   assign ilim     = $signed({19'd0, integ_lim_ff});

   always_comb begin
      if (isum > ilim) begin
         integ_new_in = INTEG_W'(ilim);
         sat_in       = 1'b1;
      end else if (isum < -ilim) begin
         integ_new_in = INTEG_W'(-ilim);
         sat_in       = 1'b1;
      end else begin
         integ_new_in = INTEG_W'(isum);
         sat_in       = 1'b0;
      end
   end

   assign dp_in   = d_gain_ff * c_derr_ff;
   assign pv_in   = (58'(c_pp_ff) <<< 8) + 58'(c_vp_ff);
   assign wr_en   = en && c_vld_ff && c_inr_ff;
   assign wr_addr = c_joint_ff[ADDR_W-1:0];

   // stage d: everything at q24 resolution
   logic signed [61:0] cmd_in;

   assign cmd_in = 62'(d_pv_ff) + (62'(d_dp_ff) <<< 8) + (62'(d_integ_ff) <<< 8)
                   + (62'(valve_bias_ff) <<< 24);

   // stage e
   logic signed [61:0] vlim;
   logic signed [37:0] cmd_q;
   logic               cmd_rnd;
   logic signed [15:0] rsp_cmd_in;

   assign vlim    = $signed({23'd0, valve_lim_ff, 24'd0});
   assign cmd_q   = e_cmd_ff[61:24];
   assign cmd_rnd = e_cmd_ff[61] && (|e_cmd_ff[23:0]);

   always_comb begin
      if (!e_inr_ff) begin
         rsp_cmd_in = '0;
      end else if (e_cmd_ff > vlim) begin
         rsp_cmd_in = $signed({1'b0, valve_lim_ff});
      end else if (e_cmd_ff < -vlim) begin
         rsp_cmd_in = -$signed({1'b0, valve_lim_ff});
      end else begin
         rsp_cmd_in = 16'(cmd_q + $signed({37'd0, cmd_rnd}));
      end
   end

   // joint state memory
   vtp_state_type     mem [NUM_JOINTS];
   logic [NUM_JOINTS-1:0] vld_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= '{sat: sat_in, last_err: c_err_ff, integ: integ_new_in};
      end
      if (en) begin
         rd_q_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            vld_ff[wr_addr] <= 1'b1;
         end
         if (en) begin
            rd_vld_ff <= vld_ff[rd_addr];
         end
      end
   end

   // valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         b_vld_ff     <= 1'b0;
         c_vld_ff     <= 1'b0;
         d_vld_ff     <= 1'b0;
         e_vld_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         b_vld_ff     <= accept;
         c_vld_ff     <= b_vld_ff;
         d_vld_ff     <= c_vld_ff;
         e_vld_ff     <= d_vld_ff;
         rsp_valid_ff <= e_vld_ff;
      end
   end

   // payload stages
   always_ff @(posedge clock) begin
      if (en) begin
         b_joint_ff   <= req_joint;
         b_inr_ff     <= inr_in;
         b_err_ff     <= err_in;
         b_vel_ff     <= req_piston_velocity;

         c_joint_ff   <= b_joint_ff;
         c_inr_ff     <= b_inr_ff;
         c_err_ff     <= b_err_ff;
         c_integ_ff   <= b_integ;
         c_leak_ff    <= leak_in;
         c_ig_ff      <= ig_in;
         c_pp_ff      <= pp_in;
         c_vp_ff      <= vp_in;
         c_derr_ff    <= derr_in;

         d_joint_ff   <= c_joint_ff;
         d_inr_ff     <= c_inr_ff;
         d_err_ff     <= c_err_ff;
         d_integ_ff   <= integ_new_in;
         d_sat_ff     <= sat_in;
         d_dp_ff      <= dp_in;
         d_pv_ff      <= pv_in;

         e_joint_ff   <= d_joint_ff;
         e_inr_ff     <= d_inr_ff;
         e_sat_ff     <= d_sat_ff;
         e_cmd_ff     <= cmd_in;

         rsp_joint_ff <= e_joint_ff;
         rsp_cmd_ff   <= rsp_cmd_in;
         rsp_sat_ff   <= e_sat_ff && e_inr_ff;
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_joint_out          = rsp_joint_ff;
   assign rsp_valve_command      = rsp_cmd_ff;
   assign rsp_integral_saturated = rsp_sat_ff;

   // the interlock keeps back-to-back items off the same joint
   a_no_adjacent_joint: assert property (@(posedge clock) disable iff (reset)
      (b_vld_ff && c_vld_ff && b_inr_ff && c_inr_ff) |-> (b_joint_ff != c_joint_ff))
      else $error("same joint in read and write-back stages");

   // a written integral always lies inside its clamp
   a_integ_bounded: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> ((integ_new_in <= $signed({1'b0, integ_lim_ff}))
                 && (integ_new_in >= -$signed({1'b0, integ_lim_ff}))))
      else $error("integral written outside its limit");

endmodule
`default_nettype wire

// ===== test/tb_valve_torque_pid.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_valve_torque_pid
// Self-checking bench for the per-joint valve torque PID. A scoreboard keeps
// its own joint state and registers, works out the command and saturation
// flag of each request transfer, and checks response transfers in order while
// the request and response sides idle and stall at random (in all but the last two phases).
// ----------------------------------------------------------------------------
module tb_valve_torque_pid;
   import vtp_pkg::*;

   localparam int     NUM_REGS = 1 << CSR_IDX_W;
   localparam longint Q16_ONE  = 64'sd65536;
   localparam longint Q24_ONE  = 64'sd16777216;

   typedef struct {
      logic [JOINT_W-1:0] joint;
      logic signed [15:0] command;
      logic               saturated;
   } valve_result_type;

   typedef enum int {
      PLAN_DIRECTED,
      PLAN_MODERATE,
      PLAN_MAX,
      PLAN_MIN_ZERO,
      PLAN_RANDOM,
      PLAN_STRONG_LEAK,
      PLAN_UNIT_LEAK
   } plan_kind_type;

   class pid_scoreboard;
      longint p_gain, d_gain, i_gain, integ_limit;
      longint forget, vel_gain, valve_limit, valve_bias;
      longint last_err [NUM_JOINTS];
      longint integ [NUM_JOINTS];
      valve_result_type pending_commands [$];
      int errors;

      function new();
         p_gain = 0; d_gain = 0; i_gain = 0; integ_limit = 0;
         forget = FORGET_RESET; vel_gain = 0; valve_limit = 0; valve_bias = 0;
         foreach (last_err[j]) begin
            last_err[j] = 0;
            integ[j]    = 0;
         end
         errors = 0;
      endfunction

      function void set_register(csr_reg_type idx, logic [31:0] data);
         case (idx)
            CSR_P_GAIN:         p_gain      = $signed(data);
            CSR_D_GAIN_SCALED:  d_gain      = $signed(data);
            CSR_I_GAIN:         i_gain      = $signed(data);
            CSR_INTEGRAL_LIMIT: integ_limit = data[30:0];
            CSR_FORGET_COEF:    forget      = data[16:0];
            CSR_VEL_GAIN:       vel_gain    = $signed(data);
            CSR_VALVE_LIMIT:    valve_limit = data[14:0];
            CSR_VALVE_BIAS:     valve_bias  = $signed(data[15:0]);
            default: ;
         endcase
      endfunction

      function void note_request(logic [JOINT_W-1:0] joint, logic signed [15:0] des,
                                 logic signed [15:0] act, logic signed [15:0] vel);
         longint err, derr, acc, cmd, lim;
         valve_result_type r;
         r.joint     = joint;
         r.command   = '0;
         r.saturated = 1'b0;
         if (joint < NUM_JOINTS) begin
            err  = longint'(des) - longint'(act);
            derr = err - last_err[joint];
            // leak first, truncated toward zero, then the new error
            acc  = integ[joint];
            acc  = acc - (acc * forget) / Q16_ONE;
            acc  = acc + i_gain * err;
            if (acc > integ_limit) begin
               acc = integ_limit;
               r.saturated = 1'b1;
            end else if (acc < -integ_limit) begin
               acc = -integ_limit;
               r.saturated = 1'b1;
            end
            integ[joint]    = acc;
            last_err[joint] = err;
            // sum at Q.24 so nothing rounds before the clamp
            cmd = p_gain * err * 256 + acc * 256 + d_gain * derr * 256
                + vel_gain * longint'(vel) + valve_bias * Q24_ONE;
            lim = valve_limit * Q24_ONE;
            if (cmd > lim)
               cmd = lim;
            else if (cmd < -lim)
               cmd = -lim;
            cmd = cmd / Q24_ONE;
            r.command = cmd[15:0];
         end
         pending_commands.push_back(r);
      endfunction

      function void check_command(logic [JOINT_W-1:0] joint, logic signed [15:0] cmd,
                                  logic sat);
         valve_result_type want;
         if (pending_commands.size() == 0) begin
            $display("%0t: unexpected response, joint_out %0d valve_command %0d",
                     $time, joint, cmd);
            errors++;
            return;
         end
         want = pending_commands.pop_front();
         if (joint !== want.joint) begin
            $display("%0t: joint_out expected %0d actual %0d", $time, want.joint, joint);
            errors++;
         end
         if (cmd !== want.command) begin
            $display("%0t: valve_command expected %0d actual %0d",
                     $time, want.command, cmd);
            errors++;
         end
         if (sat !== want.saturated) begin
            $display("%0t: integral_saturated expected %0b actual %0b",
                     $time, want.saturated, sat);
            errors++;
         end
      endfunction
   endclass

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic [JOINT_W-1:0]         req_joint = '0;
   logic signed [TORQUE_W-1:0] req_desired_torque = '0;
   logic signed [TORQUE_W-1:0] req_actual_torque = '0;
   logic signed [15:0]         req_piston_velocity = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic [JOINT_W-1:0]         rsp_joint_out;
   logic signed [15:0]         rsp_valve_command;
   logic                       rsp_integral_saturated;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [CSR_IDX_W-1:0]       csr_index = '0;
   logic [CSR_DATA_W-1:0]      csr_wdata = '0;

   pid_scoreboard board = new();

   logic [31:0]        reg_plan [NUM_REGS];
   logic [JOINT_W-1:0] last_joint = '0;
   int                 send_idle_pct = 0;
   int                 recv_stall_pct = 0;

   valve_torque_pid u_top (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_joint              (req_joint),
      .req_desired_torque     (req_desired_torque),
      .req_actual_torque      (req_actual_torque),
      .req_piston_velocity    (req_piston_velocity),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_joint_out          (rsp_joint_out),
      .rsp_valve_command      (rsp_valve_command),
      .rsp_integral_saturated (rsp_integral_saturated),
      .csr_valid              (csr_valid),
      .csr_ready              (csr_ready),
      .csr_index              (csr_index),
      .csr_wdata              (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   // transfers are taken from the values seen just before the edge
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready)
            board.set_register(csr_reg_type'(csr_index), csr_wdata);
         if (req_valid && !req_stall)
            board.note_request(req_joint, req_desired_torque, req_actual_torque,
                               req_piston_velocity);
         if (rsp_valid && !rsp_stall)
            board.check_command(rsp_joint_out, rsp_valve_command, rsp_integral_saturated);
      end
   end

   function automatic logic [31:0] signed_random(int unsigned mag);
      return $urandom_range(0, 2 * mag) - mag;
   endfunction

   function automatic logic signed [15:0] extreme_value();
      case ($urandom_range(4))
         0:       return 16'sh7FFF;
         1:       return 16'sh8000;
         2:       return 16'sh0000;
         3:       return 16'shFFFF;
         default: return 16'sh0001;
      endcase
   endfunction

   task automatic build_plan(input plan_kind_type kind);
      case (kind)
         PLAN_DIRECTED: begin
            reg_plan[CSR_P_GAIN]         = 32'h0001_0000;
            reg_plan[CSR_D_GAIN_SCALED]  = 32'h0000_8000;
            reg_plan[CSR_I_GAIN]         = 32'h0000_1000;
            reg_plan[CSR_INTEGRAL_LIMIT] = 32'h0010_0000;
            reg_plan[CSR_FORGET_COEF]    = 32'd65;
            reg_plan[CSR_VEL_GAIN]       = 32'h0000_0100;
            reg_plan[CSR_VALVE_LIMIT]    = 32'd32767;
            reg_plan[CSR_VALVE_BIAS]     = 32'd0;
         end
         PLAN_MAX: begin
            // upper bits of the narrow registers carry junk that must be dropped
            reg_plan[CSR_P_GAIN]         = 32'h7FFF_FFFF;
            reg_plan[CSR_D_GAIN_SCALED]  = 32'h8000_0000;
            reg_plan[CSR_I_GAIN]         = 32'h7FFF_FFFF;
            reg_plan[CSR_INTEGRAL_LIMIT] = 32'hFFFF_FFFF;
            reg_plan[CSR_FORGET_COEF]    = 32'hFFFE_0000;
            reg_plan[CSR_VEL_GAIN]       = 32'h8000_0000;
            reg_plan[CSR_VALVE_LIMIT]    = 32'hFFFF_7FFF;
            reg_plan[CSR_VALVE_BIAS]     = 32'h5A5A_8000;
         end
         PLAN_MIN_ZERO: begin
            reg_plan[CSR_P_GAIN]         = 32'h8000_0000;
            reg_plan[CSR_D_GAIN_SCALED]  = 32'h7FFF_FFFF;
            reg_plan[CSR_I_GAIN]         = 32'h8000_0000;
            reg_plan[CSR_INTEGRAL_LIMIT] = 32'h8000_0000;
            reg_plan[CSR_FORGET_COEF]    = 32'hFFFF_FFFF;
            reg_plan[CSR_VEL_GAIN]       = 32'h7FFF_FFFF;
            reg_plan[CSR_VALVE_LIMIT]    = 32'hFFFF_8000;
            reg_plan[CSR_VALVE_BIAS]     = 32'h0000_7FFF;
         end
         PLAN_RANDOM: begin
            foreach (reg_plan[i])
               reg_plan[i] = $urandom();
         end
         default: begin
            reg_plan[CSR_P_GAIN]         = signed_random(1 << 18);
            reg_plan[CSR_D_GAIN_SCALED]  = signed_random(1 << 17);
            reg_plan[CSR_I_GAIN]         = signed_random(1 << 14);
            reg_plan[CSR_INTEGRAL_LIMIT] = $urandom_range(0, 1 << 28);
            reg_plan[CSR_FORGET_COEF]    = $urandom_range(1, 65536);
            reg_plan[CSR_VEL_GAIN]       = signed_random(1 << 18);
            reg_plan[CSR_VALVE_LIMIT]    = $urandom_range(0, 32767);
            reg_plan[CSR_VALVE_BIAS]     = signed_random(4096);
            if (kind == PLAN_STRONG_LEAK) begin
               // leak at least as big as the integral itself
               reg_plan[CSR_FORGET_COEF] = $urandom_range(65536, 131071);
               reg_plan[CSR_I_GAIN]      = signed_random(1 << 20);
            end else if (kind == PLAN_UNIT_LEAK) begin
               reg_plan[CSR_FORGET_COEF] = $urandom_range(1) ? 32'd65536 : 32'd1;
            end
         end
      endcase
   endtask

   task automatic write_registers();
      for (int i = 0; i < NUM_REGS; i++) begin
         csr_valid <= 1'b1;
         csr_index <= CSR_IDX_W'(i);
         csr_wdata <= reg_plan[i];
         do begin
            @(posedge clock);
         end while (!csr_ready);
      end
      csr_valid <= 1'b0;
   endtask

   task automatic send_request(input logic [JOINT_W-1:0] joint,
                               input logic signed [15:0] des, input logic signed [15:0] act,
                               input logic signed [15:0] vel);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_joint           <= joint;
      req_desired_torque  <= des;
      req_actual_torque   <= act;
      req_piston_velocity <= vel;
      do begin
         @(posedge clock);
      end while (req_stall);
      last_joint = joint;
   endtask

   task automatic send_random();
      logic [JOINT_W-1:0] joint;
      logic signed [15:0] des, act, vel;
      // back-to-back hits on one joint exercise the state write-back hazard
      joint = ($urandom_range(99) < 30) ? last_joint : JOINT_W'($urandom_range(15));
      des   = 16'($urandom());
      case ($urandom_range(3))
         0:       act = 16'($urandom());
         1:       act = des + 16'($urandom_range(0, 128)) - 16'sd64;
         2:       act = des;
         default: begin
            des = extreme_value();
            act = extreme_value();
         end
      endcase
      vel = ($urandom_range(9) == 0) ? extreme_value() : 16'($urandom());
      send_request(joint, des, act, vel);
   endtask

   task automatic drain();
      // let the monitor note the last request transfer first
      @(posedge clock);
      while (board.pending_commands.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   plan_kind_type phase_plan [6] = '{PLAN_MODERATE, PLAN_MAX, PLAN_STRONG_LEAK,
                                     PLAN_MIN_ZERO, PLAN_RANDOM, PLAN_UNIT_LEAK};

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      send_idle_pct  = 21;
      recv_stall_pct = 46;

      build_plan(PLAN_DIRECTED);
      write_registers();
      send_request(4'd0,  16'sd0,      16'sd0,      16'sd0);
      send_request(4'd15, 16'sh7FFF,   16'sh8000,   16'sd0);
      send_request(4'd15, 16'sh8000,   16'sh7FFF,   16'sd0);
      send_request(4'd15, 16'sh8000,   16'sh7FFF,   16'sh7FFF);
      send_request(4'd1,  16'sh7FFF,   16'sh8000,   16'sh8000);
      send_request(4'd1,  16'sh7FFF,   16'sh8000,   16'sh7FFF);
      send_request(4'd2,  16'sd100,    16'sd0,      16'sd0);
      send_request(4'd2,  16'sd100,    16'sd0,      16'sd0);
      send_request(4'd2,  16'sd100,    16'sd0,      16'sd0);
      send_request(4'd3,  -16'sd100,   16'sd0,      16'sd256);
      send_request(4'd3,  16'sd0,      16'sd0,      -16'sd1);
      send_request(4'd4,  16'sd1,      16'sd0,      16'sh5555);
      send_request(4'd5,  16'shAAAA,   16'sh5555,   16'shAAAA);
      send_request(4'd6,  16'sh5555,   16'shAAAA,   16'sd0);
      send_request(4'd7,  16'sd12,     16'sd12,     16'sd0);
      send_request(4'd8,  16'shFFFF,   16'sh0001,   16'sh00FF);
      send_request(4'd9,  16'sh7FFF,   16'sh7FFF,   16'sh8000);
      send_request(4'd15, 16'sd0,      16'sd0,      16'sd0);
      req_valid <= 1'b0;
      drain();

      for (int phase = 0; phase < 6; phase++) begin
         if (phase < 2) begin
            send_idle_pct  = 21;
            recv_stall_pct = 46;
         end else if (phase < 4) begin
            send_idle_pct  = 46;
            recv_stall_pct = 21;
         end else begin
            send_idle_pct  = 0;
            recv_stall_pct = 0;
         end
         build_plan(phase_plan[phase]);
         write_registers();
         repeat (240) send_random();
         req_valid <= 1'b0;
         drain();
      end

      if (board.errors == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

   initial begin
      #2000000;
      $display("TEST FAILED");
      $finish;
   end

endmodule

// ===== valve_torque_pid.f =====
hw/rtl/vtp_pkg.sv
hw/rtl/valve_torque_pid.sv
test/tb_valve_torque_pid.sv
